// File: src/sst_pkg.sv
// sst_pkg: shared types and constants for the sparse set table
// command codes, controller states, and the control/status structs
// no dependencies
package sst_pkg;

  localparam int KEY_W    = 8;
  localparam int CNT_W    = 8;
  localparam int POS_W    = 8;
  localparam int CMD_W    = 3;
  localparam int NUM_KEYS = 2 ** KEY_W;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD = 3'd0,
    CMD_DEL = 3'd1,
    CMD_HAS = 3'd2,
    CMD_CLR = 3'd3,
    CMD_AT  = 3'd4
  } cmd_e;

  typedef enum logic [0:0] {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic ready;   // idle, taking a new command
    logic load;    // capture the command this cycle
    logic commit;  // apply updates and register the result
  } ctl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_busy;  // result register full and not taken this cycle
  } dp_stat_t;

endpackage

// File: src/sst_if.sv
// sst_if: valid/ready channel interfaces for the sparse set table
// command channel and result channel
// depends on sst_pkg
interface sst_in_if
  import sst_pkg::*;
;
  logic             valid;
  logic             ready;
  logic [CMD_W-1:0] cmd;
  logic [KEY_W-1:0] key;
  logic [POS_W-1:0] position;

  modport source (output valid, output cmd, output key, output position, input ready);
  modport sink   (input valid, input cmd, input key, input position, output ready);
endinterface

interface sst_out_if
  import sst_pkg::*;
;
  logic             valid;
  logic             ready;
  logic             ok;
  logic [CNT_W-1:0] count;
  logic [KEY_W-1:0] key_out;

  modport source (output valid, output ok, output count, output key_out, input ready);
  modport sink   (input valid, input ok, input count, input key_out, output ready);
endinterface

// File: src/sst_ram.sv
// sst_ram: generic single-write, single-read RAM with registered read data
// used for the sparse map and the dense key list
// no dependencies
module sst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: src/sst_ctrl.sv
// sst_ctrl: command sequencer for the sparse set table
// idle/read cycle, then execute cycle that waits for the result register
// depends on sst_pkg
module sst_ctrl
  import sst_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  dp_stat_t stat,
  output ctl_cmd_t ctl
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (!stat.out_busy) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    ctl = '0;
    unique case (state_r)
      ST_IDLE: begin
        ctl.ready = 1'b1;
        ctl.load  = in_valid;
      end
      ST_EXEC: begin
        ctl.commit = !stat.out_busy;
      end
      default: ctl = '0;
    endcase
  end

endmodule

// File: src/sst_dp.sv
// sst_dp: datapath of the sparse set table
// sparse map and dense list RAMs, sparse valid bits, member count, result register
// depends on sst_pkg and sst_ram
module sst_dp
  import sst_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  ctl_cmd_t         ctl,
  output dp_stat_t         stat,
  input  logic [CMD_W-1:0] in_cmd,
  input  logic [KEY_W-1:0] in_key,
  input  logic [POS_W-1:0] in_position,
  input  logic             out_ready,
  output logic             out_valid,
  output logic             out_ok,
  output logic [CNT_W-1:0] out_count,
  output logic [KEY_W-1:0] out_key_out
);

  // captured command
  logic [CMD_W-1:0] cmd_r;
  logic [KEY_W-1:0] key_r;
  logic [POS_W-1:0] pos_r;

  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [NUM_KEYS-1:0] valid_r, valid_nxt;

  logic             out_valid_r, out_valid_nxt;
  logic             out_ok_r;
  logic [CNT_W-1:0] out_count_r;
  logic [KEY_W-1:0] out_key_r;

  // ram ports
  logic             sp_we, dn_we;
  logic [KEY_W-1:0] sp_waddr, sp_raddr;
  logic [CNT_W-1:0] sp_wdata, sp_rdata;
  logic [CNT_W-1:0] dn_waddr, dn_raddr;
  logic [KEY_W-1:0] dn_wdata, dn_rdata;

  logic             present, key_nz;
  logic             ok;
  logic [KEY_W-1:0] kout;
  logic             set_en, clr_en, clr_all;
  logic [KEY_W-1:0] set_idx, clr_idx;
  logic [CMD_W-1:0] rd_cmd;
  logic [POS_W-1:0] rd_pos;

  assign stat.out_busy = out_valid_r && !out_ready;

  // read addresses come from the input while idle, from the captured command after
  assign rd_cmd   = ctl.ready ? in_cmd : cmd_r;
  assign rd_pos   = ctl.ready ? in_position : pos_r;
  assign sp_raddr = ctl.ready ? in_key : key_r;
  assign dn_raddr = (rd_cmd == CMD_AT) ? CNT_W'(rd_pos) : count_r - CNT_W'(1);

  sst_ram #(.WIDTH(CNT_W), .DEPTH(NUM_KEYS)) u_sparse (
    .clk   (clk),
    .we    (sp_we),
    .waddr (sp_waddr),
    .wdata (sp_wdata),
    .raddr (sp_raddr),
    .rdata (sp_rdata)
  );

  sst_ram #(.WIDTH(KEY_W), .DEPTH(NUM_KEYS)) u_dense (
    .clk   (clk),
    .we    (dn_we),
    .waddr (dn_waddr),
    .wdata (dn_wdata),
    .raddr (dn_raddr),
    .rdata (dn_rdata)
  );

  // an invalid sparse entry reads as absent, so clear and reset need no sweep
  assign present = valid_r[key_r];
  assign key_nz  = key_r != '0;

  always_comb begin
    ok        = 1'b0;
    kout      = '0;
    count_nxt = count_r;
    sp_we     = 1'b0;
    sp_waddr  = key_r;
    sp_wdata  = '0;
    dn_we     = 1'b0;
    dn_waddr  = count_r;
    dn_wdata  = key_r;
    set_en    = 1'b0;
    set_idx   = key_r;
    clr_en    = 1'b0;
    clr_idx   = key_r;
    clr_all   = 1'b0;
    unique case (cmd_r)
      CMD_ADD: begin
        if (key_nz && !present) begin
          dn_we     = 1'b1;
          sp_we     = 1'b1;
          sp_wdata  = count_r + CNT_W'(1);
          set_en    = 1'b1;
          count_nxt = count_r + CNT_W'(1);
          ok        = 1'b1;
        end
      end
      CMD_DEL: begin
        if (key_nz && present) begin
          // move the last dense key into the freed slot
          dn_we     = 1'b1;
          dn_waddr  = sp_rdata - CNT_W'(1);
          dn_wdata  = dn_rdata;
          sp_we     = 1'b1;
          sp_waddr  = dn_rdata;
          sp_wdata  = sp_rdata;
          set_en    = 1'b1;
          set_idx   = dn_rdata;
          clr_en    = 1'b1;
          count_nxt = count_r - CNT_W'(1);
          ok        = 1'b1;
        end
      end
      CMD_HAS: begin
        ok = key_nz && present;
      end
      CMD_CLR: begin
        clr_all   = 1'b1;
        count_nxt = '0;
        ok        = 1'b1;
      end
      CMD_AT: begin
        if (CNT_W'(pos_r) < count_r) begin
          ok   = 1'b1;
          kout = dn_rdata;
        end
      end
      default: ok = 1'b0;
    endcase
    sp_we = sp_we && ctl.commit;
    dn_we = dn_we && ctl.commit;
  end

  // removal wins over the moved key when the deleted key was the last one
  always_comb begin
    valid_nxt = valid_r;
    if (ctl.commit) begin
      if (clr_all) begin
        valid_nxt = '0;
      end else begin
        if (set_en) begin
          valid_nxt[set_idx] = 1'b1;
        end
        if (clr_en) begin
          valid_nxt[clr_idx] = 1'b0;
        end
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (ctl.commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (ctl.commit) begin
        count_r <= count_nxt;
      end
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_r <= in_cmd;
      key_r <= in_key;
      pos_r <= in_position;
    end
    if (ctl.commit) begin
      out_ok_r    <= ok;
      out_count_r <= count_nxt;
      out_key_r   <= kout;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_ok      = out_ok_r;
  assign out_count   = out_count_r;
  assign out_key_out = out_key_r;

endmodule

// File: src/sparse_set_table.sv
// sparse_set_table: top level of the sparse set of 8-bit keys
// depends on sst_pkg, sst_if, sst_ctrl and sst_dp
//
// Usage:
//   in_chan carries one command per transfer: cmd (add, delete, contains,
//   clear, read at position), key and position. out_chan returns exactly one
//   result per command: ok, count (members after the command) and key_out.
//   Key 0 is never a member.
// Timing:
//   a command is taken in the idle cycle, which also reads the sparse map and
//   dense list RAMs; the execute cycle then updates the RAMs, valid bits and
//   count and loads the result register. A new command is taken only after
//   the execute cycle of the last one, as the registered RAM read is
//   followed by the write-back cycle.
// Reset and clear:
//   rst_n (synchronous, active low) empties the set: a valid bit per sparse
//   entry is cleared, so no sweep over the RAM runs. Clear works the same
//   way in its execute cycle.
// Stall:
//   while a result waits on out_chan, the next command is still taken and
//   read; it holds in its execute cycle until the result register frees.
module sparse_set_table
  import sst_pkg::*;
(
  input logic clk,
  input logic rst_n,
  sst_in_if.sink    in_chan,
  sst_out_if.source out_chan
);

  ctl_cmd_t ctl_cmd;
  dp_stat_t dp_stat;

  assign in_chan.ready = ctl_cmd.ready;

  sst_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .stat     (dp_stat),
    .ctl      (ctl_cmd)
  );

  sst_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctl         (ctl_cmd),
    .stat        (dp_stat),
    .in_cmd      (in_chan.cmd),
    .in_key      (in_chan.key),
    .in_position (in_chan.position),
    .out_ready   (out_chan.ready),
    .out_valid   (out_chan.valid),
    .out_ok      (out_chan.ok),
    .out_count   (out_chan.count),
    .out_key_out (out_chan.key_out)
  );

  // a result is never overwritten while it waits
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    ctl_cmd.commit |-> !dp_stat.out_busy)
    else $error("result register overwritten while stalled");

  // a taken command blocks the input for its execute cycle
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_chan.valid && in_chan.ready) |=> !in_chan.ready)
    else $error("command taken during execute cycle");

  // a new result only follows an execute cycle
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_chan.valid) |-> $past(ctl_cmd.commit))
    else $error("result valid without execute");

endmodule
